[rtl/ttd_pkg.sv]
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared constants and controller/datapath interface types for the
// trial-division totient block.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int FIRST_DIVISOR   = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input value
    logic div_start;   // launch the divider
    logic div_acc;     // dividend is the accumulator (else the remainder value)
    logic div_by_rem;  // divisor is the remainder value (else the trial divisor)
    logic rem_take_q;  // remainder value <= quotient
    logic acc_sub_q;   // accumulator <= accumulator - quotient
    logic d_step;      // advance the trial divisor
    logic out_load;    // copy the accumulator to the output register
  } ttd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;    // divider finished this cycle
    logic rem_zero;    // divider remainder is zero
    logic past_root;   // d * d exceeds the remainder value
    logic rem_gt_one;  // remainder value above one
  } ttd_status_t;

endpackage

[rtl/ttd_divider.sv]
// ----------------------------------------------------------------------------
// ttd_divider
// Restoring divider, one quotient bit per cycle. Dividend and divisor are
// captured at start. Result is valid when done pulses and holds until the
// next start.
// ----------------------------------------------------------------------------
module ttd_divider #(
  parameter int VALUE_WIDTH = ttd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH:0]   part;

  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   ge;
  logic [VALUE_WIDTH:0]   part_next;

  always_comb begin
    shifted   = {part[VALUE_WIDTH-1:0], quo[VALUE_WIDTH-1]};
    diff      = {1'b0, shifted} - {2'b00, dvs};
    ge        = ~diff[VALUE_WIDTH+1];
    part_next = ge ? diff[VALUE_WIDTH:0] : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(VALUE_WIDTH);
        quo <= dividend;
        dvs <= divisor;
        part <= '0;
      end else if (busy) begin
        part <= part_next;
        quo <= {quo[VALUE_WIDTH-2:0], ge};
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = part[VALUE_WIDTH-1:0];

endmodule

[rtl/ttd_datapath.sv]
// ----------------------------------------------------------------------------
// ttd_datapath
// Accumulator, remainder value, trial divisor with its running square, the
// shared divider and the output register.
// ----------------------------------------------------------------------------
module ttd_datapath #(
  parameter int VALUE_WIDTH = ttd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ttd_pkg::ttd_cmd_t      cmd,
  output ttd_pkg::ttd_status_t   status,
  input  logic [VALUE_WIDTH-1:0] n_value,
  output logic [VALUE_WIDTH-1:0] totient
);

  // The trial divisor never passes sqrt(2^VALUE_WIDTH) + 1.
  localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SW = VALUE_WIDTH + 1;

  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] rem;
  logic [DW-1:0]          d;
  logic [SW-1:0]          dsq;
  logic [VALUE_WIDTH-1:0] result;

  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  assign div_dividend = cmd.div_acc ? acc : rem;
  assign div_divisor  = cmd.div_by_rem ? rem : VALUE_WIDTH'(d);

  ttd_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= n_value;
      rem <= n_value;
      d   <= DW'(ttd_pkg::FIRST_DIVISOR);
      dsq <= SW'(ttd_pkg::FIRST_DIVISOR * ttd_pkg::FIRST_DIVISOR);
    end else begin
      if (cmd.rem_take_q) begin
        rem <= div_quo;
      end
      if (cmd.acc_sub_q) begin
        // acc is a multiple of the divisor here, so acc / p * (p - 1) = acc - acc / p
        acc <= acc - div_quo;
      end
      if (cmd.d_step) begin
        // (d + 1)^2 = d^2 + 2d + 1
        dsq <= dsq + SW'({d, 1'b1});
        d   <= d + DW'(1);
      end
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end

  always_comb begin
    status.div_done   = div_done;
    status.rem_zero   = (div_rem == '0);
    status.past_root  = (dsq > SW'(rem));
    status.rem_gt_one = (rem > VALUE_WIDTH'(1));
  end

  assign totient = result;

endmodule

[rtl/ttd_control.sv]
// ----------------------------------------------------------------------------
// ttd_control
// Sequencer for the trial-division loop, input handshake and output valid.
// ----------------------------------------------------------------------------
module ttd_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 n_value_valid,
  output logic                 n_value_stall,
  output logic                 totient_valid,
  input  logic                 totient_stall,
  input  ttd_pkg::ttd_status_t status,
  output ttd_pkg::ttd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    REM_WAIT,
    REM_AGAIN,
    ACC_WAIT,
    FINAL,
    FINAL_WAIT,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   applied;
  logic   out_free;

  assign out_free      = !totient_valid || !totient_stall;
  assign n_value_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (n_value_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (status.past_root) begin
          state_next = FINAL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = REM_WAIT;
        end
      end
      REM_WAIT: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.rem_take_q = 1'b1;
            if (!applied) begin
              // apply the factor once, then keep dividing it out
              cmd.div_start = 1'b1;
              cmd.div_acc   = 1'b1;
              state_next    = ACC_WAIT;
            end else begin
              state_next = REM_AGAIN;
            end
          end else begin
            cmd.d_step = 1'b1;
            state_next = CHECK;
          end
        end
      end
      REM_AGAIN: begin
        cmd.div_start = 1'b1;
        state_next    = REM_WAIT;
      end
      ACC_WAIT: begin
        if (status.div_done) begin
          cmd.acc_sub_q = 1'b1;
          state_next    = REM_AGAIN;
        end
      end
      FINAL: begin
        if (status.rem_gt_one) begin
          cmd.div_start  = 1'b1;
          cmd.div_acc    = 1'b1;
          cmd.div_by_rem = 1'b1;
          state_next     = FINAL_WAIT;
        end else begin
          state_next = DONE;
        end
      end
      FINAL_WAIT: begin
        if (status.div_done) begin
          cmd.acc_sub_q = 1'b1;
          state_next    = DONE;
        end
      end
      DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      applied       <= 1'b0;
      totient_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load || cmd.d_step) begin
        applied <= 1'b0;
      end else if (cmd.div_acc) begin
        applied <= 1'b1;
      end
      if (cmd.out_load) begin
        totient_valid <= 1'b1;
      end else if (!totient_stall) begin
        // drop valid once the beat is taken
        totient_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/totient_trial_division_top.sv]
// ----------------------------------------------------------------------------
// totient_trial_division_top
// Euler totient phi(n) by trial division.
//
// Input channel n_value / n_value_valid / n_value_stall carries one value per
// beat; the result leaves on totient / totient_valid / totient_stall, one
// beat per input, in order. A beat moves when valid is high and stall low.
// One value is worked at a time: n_value_stall is high from acceptance until
// the result is moved into the output register.
// Each trial divisor d (2, 3, ... while d*d <= remaining value) launches the
// shared divider once and waits until its result is taken. A divisor that
// divides adds one accumulator division, and one remainder division per
// power of it. A final prime factor adds one more division. The run time is
// set by these divisions on the single shared restoring divider.
// A stalled result holds in the output register; the block finishes the next
// value's work and waits before overwriting it.
// Reset clears the sequencer and output valid; no value is in flight after.
// ----------------------------------------------------------------------------
module totient_trial_division_top #(
  parameter int VALUE_WIDTH = ttd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] n_value,
  input  logic                   n_value_valid,
  output logic                   n_value_stall,
  output logic [VALUE_WIDTH-1:0] totient,
  output logic                   totient_valid,
  input  logic                   totient_stall
);

  ttd_pkg::ttd_cmd_t    cmd;
  ttd_pkg::ttd_status_t status;

  ttd_control u_control (
    .clk           (clk),
    .rst           (rst),
    .n_value_valid (n_value_valid),
    .n_value_stall (n_value_stall),
    .totient_valid (totient_valid),
    .totient_stall (totient_stall),
    .status        (status),
    .cmd           (cmd)
  );

  ttd_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .n_value (n_value),
    .totient (totient)
  );

endmodule

[test/totient_checker.sv]
// ----------------------------------------------------------------------------
// totient_checker
// Watches both channels of the trial-division totient block. Every accepted
// input beat queues phi(n), worked out here by plain trial division; every
// accepted result beat is compared with the oldest queued value.
// ----------------------------------------------------------------------------
module totient_checker #(
  parameter int VALUE_WIDTH = ttd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] n_value,
  input  logic                   n_value_valid,
  input  logic                   n_value_stall,
  input  logic [VALUE_WIDTH-1:0] totient,
  input  logic                   totient_valid,
  input  logic                   totient_stall,
  output int                     fail_count,
  output int                     open_count,
  output int                     results_seen
);

  localparam int REPORT_MAX = 10;

  logic [VALUE_WIDTH-1:0] phi_q[$];
  logic [VALUE_WIDTH-1:0] want;

  function automatic logic [VALUE_WIDTH-1:0] phi_of(input logic [VALUE_WIDTH-1:0] n);
    longint unsigned acc;
    longint unsigned left;
    longint unsigned d;
    if (n < 2) return n;
    acc  = n;
    left = n;
    // stop once d*d passes what is left of n
    for (d = ttd_pkg::FIRST_DIVISOR; d <= left / d; d++) begin
      if (left % d == 0) begin
        acc = acc / d * (d - 1);
        while (left % d == 0) left = left / d;
      end
    end
    // what remains above one is a prime factor
    if (left > 1) acc = acc / left * (left - 1);
    return acc[VALUE_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phi_q.delete();
      open_count <= 0;
    end else begin
      // result first: it belongs to an earlier input beat
      if (totient_valid && !totient_stall) begin
        results_seen <= results_seen + 1;
        if (phi_q.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("[%0t] unexpected result beat: totient=%0d", $realtime, totient);
          fail_count <= fail_count + 1;
        end else begin
          want = phi_q.pop_front();
          if (totient !== want) begin
            if (fail_count < REPORT_MAX)
              $display("[%0t] result %0d: totient expected %0d, got %0d",
                       $realtime, results_seen, want, totient);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (n_value_valid && !n_value_stall) phi_q.push_back(phi_of(n_value));
      open_count <= phi_q.size();
    end
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the trial-division totient block: corner values first, then
// random values weighted toward cheap factorizations, with random gaps on
// both channels, one long result hold-off and one drain pause. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int              W            = ttd_pkg::VALUE_WIDTH_DEF;
  localparam longint unsigned MAX_VALUE    = (64'd1 << W) - 1;
  localparam int              RANDOM_ITEMS = 100;
  localparam int              HOLD_CYCLES  = 400;
  localparam int              DRAIN_CYCLES = 200;
  localparam longint          LIMIT_CYCLES = 20000000;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic [W-1:0] n_value       = '0;
  logic         n_value_valid = 1'b0;
  logic         n_value_stall;
  logic [W-1:0] totient;
  logic         totient_valid;
  logic         totient_stall = 1'b0;

  logic         hold_go   = 1'b0;
  logic         hold_done = 1'b0;
  logic         no_idle   = 1'b0;
  int           hold_left = 0;
  int           rx_wait   = 0;
  int           rx_draw;
  int           sent      = 0;
  longint       cycle_count = 0;

  int           fail_count;
  int           open_count;
  int           results_seen;

  logic [W-1:0] corner_q[$];

  always #6 clk = ~clk;

  totient_trial_division_top dut (
    .clk           (clk),
    .rst           (rst),
    .n_value       (n_value),
    .n_value_valid (n_value_valid),
    .n_value_stall (n_value_stall),
    .totient       (totient),
    .totient_valid (totient_valid),
    .totient_stall (totient_stall)
  );

  totient_checker #(.VALUE_WIDTH(W)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .n_value       (n_value),
    .n_value_valid (n_value_valid),
    .n_value_stall (n_value_stall),
    .totient       (totient),
    .totient_valid (totient_valid),
    .totient_stall (totient_stall),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .results_seen  (results_seen)
  );

  // Receiver: random wait per result beat, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      totient_stall <= 1'b0;
      rx_wait       <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      totient_stall <= (hold_left > 1);
    end else if (hold_go && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      totient_stall <= 1'b1;
    end else if (totient_valid && !totient_stall) begin
      rx_draw = no_idle ? 0 : $urandom_range(0, 3);
      rx_wait       <= rx_draw;
      totient_stall <= (rx_draw != 0);
    end else if (totient_valid && rx_wait > 0) begin
      // count the wait only while a result is on offer
      rx_wait       <= rx_wait - 1;
      totient_stall <= (rx_wait > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still open", cycle_count, open_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly small values; large ones are built so their factorization stays cheap.
  function automatic logic [W-1:0] draw_value();
    longint unsigned v;
    longint unsigned p;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      v = $urandom_range(0, 4095);
    end else if (pick < 75) begin
      v = 1;
      repeat ($urandom_range(1, 16)) begin
        case ($urandom_range(0, 7))
          0: p = 2;
          1: p = 3;
          2: p = 5;
          3: p = 7;
          4: p = 11;
          5: p = 13;
          6: p = 31;
          default: p = 53;
        endcase
        if (v * p <= MAX_VALUE) v = v * p;
      end
    end else if (pick < 90) begin
      v = $urandom_range(1, 4095);
      v = v << $urandom_range(0, 19);
    end else begin
      v = $urandom_range(0, 1048575);
    end
    return v[W-1:0];
  endfunction

  task automatic send_value(input logic [W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      n_value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    n_value       <= v;
    n_value_valid <= 1'b1;
    do @(posedge clk); while (n_value_stall);
    sent++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero, unit, tiny values, prime and prime-square, powers, the largest
    // value (a prime) and its neighbor, alternating bit patterns, a primorial
    corner_q = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd97, 31'd63001,
                 31'd999983, 31'd1024, 31'd1073741824, 31'd1162261467,
                 31'd1431655765, 31'd715827882, 31'd223092870, 31'd1073758208,
                 31'd2147483646, 31'd2147483647};
    foreach (corner_q[i]) send_value(corner_q[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 30) hold_go <= 1'b1;
      if (i == 55) begin
        // drop valid and drain everything before going on
        n_value_valid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
      end
      no_idle <= (i >= 70 && i < 85);
      send_value(draw_value());
    end
    n_value_valid <= 1'b0;

    do @(posedge clk); while (open_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d values (%0d corner values incl. zero, one and the 31-bit maximum prime),",
             sent, corner_q.size());
    $display("checked %0d results under random gaps, a long output hold-off and a drain pause",
             results_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ttd_pkg.sv
rtl/ttd_divider.sv
rtl/ttd_datapath.sv
rtl/ttd_control.sv
rtl/totient_trial_division_top.sv
test/totient_checker.sv
test/tb_top.sv
